>>> hdl/lcgs_pkg.sv
package lcgs_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int POS_OUT_W   = 12;
    localparam int GEN_W       = 32;

    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = CFG_W'(1024);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } cfg_reg_t;

    // per-item control and report info carried alongside the store read
    typedef struct packed {
        logic                 cell_bit;
        logic                 top_en;
        logic                 mid_en;
        logic                 col_zero;
        logic                 have;
        logic                 last;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] column;
        logic [GEN_W-1:0]     gen;
    } item_ctl_t;

endpackage

>>> hdl/lcgs_ram.sv
module lcgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/life_cell_generation_stencil.sv
// one b3/s23 generation per frame, one cell per request in raster order
// a request's result is held in the stage 1 register, then loaded into the output register
// throughput: one request per clock unless stalled; the store read is registered,
// write-back forwards to the next request, and a result held by out_stall stalls the input
// reset (async, rst_n low): position, window, generation count and sizes cleared
// to (0,0), zero, zero and 1024; line stores are not cleared and need no sweep
module life_cell_generation_stencil #(
    parameter int MAX_WIDTH  = lcgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lcgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lcgs_pkg::CFG_W-1:0]        cfg_data,
    // cell stream in
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cell_alive,
    // next-generation stream out
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              next_alive,
    output logic [lcgs_pkg::POS_OUT_W-1:0]    cell_row,
    output logic [lcgs_pkg::POS_OUT_W-1:0]    cell_column,
    output logic                              frame_last,
    output logic [lcgs_pkg::GEN_W-1:0]        generation
);

    // column index bits, row counter bits (rows run to height+1 for padding)
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int RB  = $clog2(MAX_HEIGHT + 2);
    localparam int SW0 = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 3)) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 3);
    // compare width, wide enough for raw register values and padded row count
    localparam int SW  = ((SW0 > lcgs_pkg::CFG_W) ? SW0 : lcgs_pkg::CFG_W) + 1;

    // b3/s23 rule on a 3x3 window, bit 4 is the centre
    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] count;
        count = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                count = count + 4'(win[i]);
            end
        end
        if (win[4])
        begin
            return (count == 4'd2) || (count == 4'd3);
        end
        return count == 4'd3;
    endfunction

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [lcgs_pkg::CFG_W-1:0] grid_width_reg;
    logic [lcgs_pkg::CFG_W-1:0] grid_height_reg;

    // sizes are to change only while idle; the block does not enforce this, and writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= lcgs_pkg::GRID_SIZE_RESET;
            grid_height_reg <= lcgs_pkg::GRID_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == lcgs_pkg::REG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data;
            end
            else if (cfg_index == lcgs_pkg::REG_GRID_HEIGHT)
            begin
                grid_height_reg <= cfg_data;
            end
        end
    end

    // effective sizes: zero acts as one, anything above the maximum as the maximum
    logic [SW-1:0] width_eff;
    logic [SW-1:0] height_eff;
    logic [SW-1:0] height_pad;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            width_eff = SW'(1);
        end
        else if (SW'(grid_width_reg) > SW'(MAX_WIDTH))
        begin
            width_eff = SW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = SW'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            height_eff = SW'(1);
        end
        else if (SW'(grid_height_reg) > SW'(MAX_HEIGHT))
        begin
            height_eff = SW'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = SW'(grid_height_reg);
        end
        // last padding row
        height_pad = height_eff + SW'(1);
    end

    // ---------------------------------------------------------------------
    // stage 0: raster position, store read issue
    // ---------------------------------------------------------------------
    logic [RB-1:0]              row_pos_reg;
    logic [RB-1:0]              row_pos_next;
    logic [CB-1:0]              col_pos_reg;
    logic [CB-1:0]              col_pos_next;
    logic [lcgs_pkg::GEN_W-1:0] gen_count_reg;
    logic [lcgs_pkg::GEN_W-1:0] gen_count_next;

    logic                       in_accept;
    logic [RB-1:0]              row_cur;
    logic [CB-1:0]              col_cur;
    logic [SW-1:0]              row_ext;
    logic [SW-1:0]              col_inc;
    logic                       frame_end;
    logic [31:0]                rep_row_wide;
    logic [31:0]                rep_col_wide;
    lcgs_pkg::item_ctl_t        ctl_cur;

    always_comb
    begin
        // abandon a frame that a size change left the position outside of
        if ((SW'(col_pos_reg) >= width_eff) || (SW'(row_pos_reg) > height_pad) ||
            ((SW'(row_pos_reg) == height_pad) && (col_pos_reg != '0)))
        begin
            row_cur = '0;
            col_cur = '0;
        end
        else
        begin
            row_cur = row_pos_reg;
            col_cur = col_pos_reg;
        end

        row_ext   = SW'(row_cur);
        col_inc   = SW'(col_cur) + SW'(1);
        frame_end = (row_ext == height_pad);

        // column 0 reports the end of the row before last, others the cell up-left
        if (col_cur == '0)
        begin
            rep_row_wide = 32'(row_cur) - 32'd2;
            rep_col_wide = 32'(width_eff) - 32'd1;
        end
        else
        begin
            rep_row_wide = 32'(row_cur) - 32'd1;
            rep_col_wide = 32'(col_cur) - 32'd1;
        end

        ctl_cur.cell_bit = (row_ext < height_eff) ? cell_alive : 1'b0;
        ctl_cur.top_en   = (row_ext >= SW'(2));
        ctl_cur.mid_en   = (row_ext >= SW'(1));
        ctl_cur.col_zero = (col_cur == '0);
        ctl_cur.have     = (col_cur == '0) ? (row_ext >= SW'(2)) : (row_ext >= SW'(1));
        ctl_cur.last     = frame_end;
        ctl_cur.row      = rep_row_wide[lcgs_pkg::POS_OUT_W-1:0];
        ctl_cur.column   = rep_col_wide[lcgs_pkg::POS_OUT_W-1:0];
        ctl_cur.gen      = gen_count_reg;

        // advance position; the last padding request closes the generation
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        gen_count_next = gen_count_reg;
        if (in_accept)
        begin
            if (frame_end)
            begin
                row_pos_next   = '0;
                col_pos_next   = '0;
                gen_count_next = gen_count_reg + lcgs_pkg::GEN_W'(1);
            end
            else if (col_inc >= width_eff)
            begin
                row_pos_next = row_cur + RB'(1);
                col_pos_next = '0;
            end
            else
            begin
                row_pos_next = row_cur;
                col_pos_next = col_inc[CB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            gen_count_reg <= '0;
        end
        else
        begin
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            gen_count_reg <= gen_count_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: store data back, window shift, rule evaluation
    // ---------------------------------------------------------------------
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [CB-1:0]       s1_addr_reg;
    lcgs_pkg::item_ctl_t s1_ctl_reg;
    logic                s1_adv;
    logic                out_free;

    // forwarding for back-to-back requests on the same column (width of one)
    logic                fwd_valid_reg;
    logic                fwd_upper_reg;
    logic                fwd_middle_reg;

    logic                upper_rd;
    logic                middle_rd;
    logic                upper_val;
    logic                middle_val;
    logic                top_bit;
    logic                mid_bit;
    logic [2:0]          column_bits;
    logic [8:0]          window_reg;
    logic [8:0]          window_next;
    logic [8:0]          eval_win;
    logic                rule_out;

    assign out_free  = !out_valid || !out_stall;
    // a request with no result drains even while the output waits
    assign s1_adv    = s1_valid_reg && (!s1_ctl_reg.have || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    lcgs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_bit),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (upper_rd)
    );

    lcgs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_ctl_reg.cell_bit),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (middle_rd)
    );

    always_comb
    begin
        upper_val   = fwd_valid_reg ? fwd_upper_reg : upper_rd;
        middle_val  = fwd_valid_reg ? fwd_middle_reg : middle_rd;
        top_bit     = s1_ctl_reg.top_en && upper_val;
        mid_bit     = s1_ctl_reg.mid_en && middle_val;
        column_bits = {s1_ctl_reg.cell_bit, mid_bit, top_bit};

        // column 0 closes the previous row with an empty right column
        if (s1_ctl_reg.col_zero)
        begin
            eval_win    = {3'b000, window_reg[8:3]};
            window_next = {column_bits, 6'b000000};
        end
        else
        begin
            eval_win    = {column_bits, window_reg[8:3]};
            window_next = eval_win;
        end
        rule_out = life_rule(eval_win);

        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                fwd_valid_reg <= s1_adv && (s1_addr_reg == col_cur);
            end
            if (s1_adv)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg    <= col_cur;
            s1_ctl_reg     <= ctl_cur;
            fwd_upper_reg  <= mid_bit;
            fwd_middle_reg <= s1_ctl_reg.cell_bit;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_load;
    logic                           next_alive_reg;
    logic [lcgs_pkg::POS_OUT_W-1:0] cell_row_reg;
    logic [lcgs_pkg::POS_OUT_W-1:0] cell_column_reg;
    logic                           frame_last_reg;
    logic [lcgs_pkg::GEN_W-1:0]     generation_reg;

    assign out_load = s1_adv && s1_ctl_reg.have;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            next_alive_reg  <= rule_out;
            cell_row_reg    <= s1_ctl_reg.row;
            cell_column_reg <= s1_ctl_reg.column;
            frame_last_reg  <= s1_ctl_reg.last;
            generation_reg  <= s1_ctl_reg.gen;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_alive  = next_alive_reg;
    assign cell_row    = cell_row_reg;
    assign cell_column = cell_column_reg;
    assign frame_last  = frame_last_reg;
    assign generation  = generation_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lcgs_pkg::*;

    // run shape
    localparam int SETTLE_CYCLES    = 8;       // results pass the stage 1 register, then the output register
    localparam int CYCLE_LIMIT      = 500000;  // well above the slowest legal run
    localparam int IDLE_PERCENT     = 17;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_FEED_DEPTH  = 20;      // feed depth that starts the long hold-off
    localparam int RANDOM_CELLS     = 500;
    localparam int CALM_FIRST       = 700;     // window with no random idling on either side
    localparam int CALM_LAST        = 1000;

    // one next-generation report
    typedef struct packed {
        logic                 next_alive;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] column;
        logic                 last;
        logic [GEN_W-1:0]     gen;
    } life_result_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = REG_GRID_WIDTH;
    logic [CFG_W-1:0]       cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic                   cell_alive  = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic                   next_alive;
    logic [POS_OUT_W-1:0]   cell_row;
    logic [POS_OUT_W-1:0]   cell_column;
    logic                   frame_last;
    logic [GEN_W-1:0]       generation;

    life_cell_generation_stencil dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_alive  (cell_alive),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_alive  (next_alive),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .frame_last  (frame_last),
        .generation  (generation)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // life stencil predictor state: two line stores, 3x3 window, raster
    // position, generation count and the two size registers
    // ------------------------------------------------------------------
    bit               upper_line  [DEF_MAX_WIDTH];
    bit               middle_line [DEF_MAX_WIDTH];
    logic [8:0]       window      = '0;
    int unsigned      row_pos     = 0;
    int unsigned      col_pos     = 0;
    logic [GEN_W-1:0] gen_count   = '0;
    logic [CFG_W-1:0] width_reg   = GRID_SIZE_RESET;
    logic [CFG_W-1:0] height_reg  = GRID_SIZE_RESET;

    life_result_t next_cell_queue[$];   // predicted reports, oldest first
    bit           cell_feed[$];         // cell requests not yet offered

    bit           failed       = 1'b0;
    bit           in_accepted  = 1'b0;
    int unsigned  cycle_count  = 0;
    int unsigned  queued_cells = 0;
    int unsigned  hold_left    = 0;
    bit           hold_done    = 1'b0;
    life_result_t want;

    // zero acts as one, anything past the store depth acts as the depth
    function automatic int unsigned clamp_grid(input logic [CFG_W-1:0] v, input int unsigned max);
        if (v == '0)
            return 1;
        return (v > max) ? max : v;
    endfunction

    // b3/s23 on a window: bit 4 is the centre, the other eight are neighbours
    function automatic logic life_rule(input logic [8:0] win);
        int n;
        n = $countones(win & 9'h1EF);
        return win[4] ? (n == 2 || n == 3) : (n == 3);
    endfunction

    task automatic predict_next_cell(input logic cell_in);
        int unsigned  w, h, r, c;
        logic         cur_cell, top, mid;
        logic [2:0]   column;
        life_result_t res;
        bit           have;
        w    = clamp_grid(width_reg, DEF_MAX_WIDTH);
        h    = clamp_grid(height_reg, DEF_MAX_HEIGHT);
        r    = row_pos;
        c    = col_pos;
        have = 1'b0;
        res  = '0;

        // a size change left us outside the frame: drop it and start over
        if (c >= w || r > h + 1 || (r == h + 1 && c != 0))
        begin
            r = 0;
            c = 0;
        end

        // padding rows carry dead cells whatever the request says
        cur_cell = (r < h) ? cell_in : 1'b0;
        top      = (r >= 2) ? upper_line[c] : 1'b0;
        mid      = (r >= 1) ? middle_line[c] : 1'b0;
        upper_line[c]  = mid;
        middle_line[c] = cur_cell;
        column = {cur_cell, mid, top};

        if (c == 0)
        begin
            // row start reports the last cell of the row two above
            if (r >= 2)
            begin
                have           = 1'b1;
                res.next_alive = life_rule(window >> 3);
                res.row        = POS_OUT_W'(r - 2);
                res.column     = POS_OUT_W'(w - 1);
                res.last       = (r == h + 1);
            end
            window = {column, 6'b0};
        end
        else
        begin
            window = {column, window[8:3]};
            if (r >= 1)
            begin
                have           = 1'b1;
                res.next_alive = life_rule(window);
                res.row        = POS_OUT_W'(r - 1);
                res.column     = POS_OUT_W'(c - 1);
                res.last       = 1'b0;
            end
        end
        res.gen = gen_count;
        if (have)
            next_cell_queue.push_back(res);

        // advance raster position, the last padding request closes the frame
        if (r == h + 1)
        begin
            r = 0;
            c = 0;
            gen_count = gen_count + 1'b1;
        end
        else
        begin
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
        end
        row_pos = r;
        col_pos = c;
    endtask

    // random idling for both sides, switched off inside the calm window
    function automatic bit idle_roll();
        if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // ------------------------------------------------------------------
    // cycle budget
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // cell request side: sample acceptance at the rising edge, drive the
    // next request at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_accepted = rst_n && in_valid && !in_stall;
        if (in_accepted)
            predict_next_cell(cell_alive);
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a stalled request holds its payload, only move on after acceptance
            if (!in_valid || in_accepted)
            begin
                if (cell_feed.size() != 0 && !idle_roll())
                begin
                    in_valid   <= 1'b1;
                    cell_alive <= cell_feed.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // report side: random stall plus one long hold-off while the feed is
    // deep, so the pipeline backs up into in_stall
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && in_valid && cell_feed.size() >= HOLD_FEED_DEPTH)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_roll();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (next_cell_queue.size() == 0)
            begin
                $display("%0t: report expected none actual row %0d column %0d",
                         $time, cell_row, cell_column);
                failed = 1'b1;
            end
            else
            begin
                want = next_cell_queue.pop_front();
                if (next_alive !== want.next_alive)
                begin
                    $display("%0t: next_alive expected %0d actual %0d",
                             $time, want.next_alive, next_alive);
                    failed = 1'b1;
                end
                if (cell_row !== want.row)
                begin
                    $display("%0t: cell_row expected %0d actual %0d", $time, want.row, cell_row);
                    failed = 1'b1;
                end
                if (cell_column !== want.column)
                begin
                    $display("%0t: cell_column expected %0d actual %0d",
                             $time, want.column, cell_column);
                    failed = 1'b1;
                end
                if (frame_last !== want.last)
                begin
                    $display("%0t: frame_last expected %0d actual %0d",
                             $time, want.last, frame_last);
                    failed = 1'b1;
                end
                if (generation !== want.gen)
                begin
                    $display("%0t: generation expected %0d actual %0d",
                             $time, want.gen, generation);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_grid_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (which == REG_GRID_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_grid_reg(REG_GRID_WIDTH, w);
        write_grid_reg(REG_GRID_HEIGHT, h);
    endtask

    // density is the percentage of live cells
    task automatic queue_cells(input int unsigned count, input int unsigned density);
        repeat (count)
        begin
            cell_feed.push_back($urandom_range(0, 99) < density);
            queued_cells++;
        end
    endtask

    // one whole frame at the current sizes, padding row plus one included
    task automatic queue_frame(input int unsigned density);
        int unsigned w, h;
        w = clamp_grid(width_reg, DEF_MAX_WIDTH);
        h = clamp_grid(height_reg, DEF_MAX_HEIGHT);
        queue_cells(w * h, density);
        queue_cells(w + 1, 50);
    endtask

    // block idle: feed empty, all reports in, then room for a request
    // that reports nothing to clear the pipeline
    task automatic wait_idle();
        while (cell_feed.size() != 0 || in_valid || next_cell_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned w_cfg, h_cfg, span, density;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero sizes act as a 1x1 grid, the lone live cell dies
        set_grid('0, '0);
        cell_feed.push_back(1'b1);
        queue_cells(2, 50);
        wait_idle();

        // vertical blinker on 3x3 turns horizontal: births, survival, deaths
        set_grid(CFG_W'(3), CFG_W'(3));
        for (int i = 0; i < 9; i++)
            cell_feed.push_back(i % 3 == 1);
        queue_cells(4, 50);
        wait_idle();

        // two cells into a frame, then shrink the width under the position:
        // frame abandoned, generation held, next request starts over
        queue_cells(2, 50);
        wait_idle();
        write_grid_reg(REG_GRID_WIDTH, CFG_W'(1));
        repeat (3) cell_feed.push_back(1'b1);
        queue_cells(2, 50);
        wait_idle();

        // one row at the widest random width writes every line store entry
        // that the random grids can reach; the long hold-off lands here
        set_grid(CFG_W'(12), CFG_W'(1));
        queue_frame(35);
        wait_idle();

        // random small grids, mostly whole frames, some cut short so the
        // next size change lands mid-frame
        queued_cells = 0;
        while (queued_cells < RANDOM_CELLS)
        begin
            w_cfg   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            h_cfg   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
            density = $urandom_range(15, 60);
            set_grid(CFG_W'(w_cfg), CFG_W'(h_cfg));
            if ($urandom_range(0, 7) == 0)
            begin
                span = clamp_grid(CFG_W'(w_cfg), DEF_MAX_WIDTH) *
                       (clamp_grid(CFG_W'(h_cfg), DEF_MAX_HEIGHT) + 1);
                queue_cells($urandom_range(1, span), density);
            end
            else
            begin
                queue_frame(density);
            end
            wait_idle();
        end

        if (failed)
            $display("Mismatches found");
        else
            $display("No mismatches found");
        $finish;
    end

endmodule
